### rtl/pcm_pkg.sv
// Shared constants for the pseudo colour mapper: field widths, opcodes,
// register indexes and reset values. No dependencies.
package pcm_pkg;

  // Payload widths of the channels.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOR_W  = 3 * CHAN_W;
  localparam int unsigned ENTRY_W  = 8;

  // Defaults of the top-level parameters.
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Opcodes of an input beat.
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd2;

  // Reset values.
  localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 32'd0;
  localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 32'd255;
  localparam logic [COLOR_W-1:0]  COLOR_FIRST    = 24'h0000FF;
  localparam logic [COLOR_W-1:0]  COLOR_LAST     = 24'hFF0000;

  // Interpolation modes.
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_EXP    = 1'b1;

endpackage

### rtl/pcm_if.sv
// Valid/ready channel interfaces for the input and result beats of the
// pseudo colour mapper. Depends on pcm_pkg for the field widths.
interface pcm_in_if;
  import pcm_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SAMPLE_W-1:0] sample;
  logic [ENTRY_W-1:0]  entry_index;
  logic [CHAN_W-1:0]   red_in;
  logic [CHAN_W-1:0]   green_in;
  logic [CHAN_W-1:0]   blue_in;

  modport source (output valid, opcode, sample, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, opcode, sample, entry_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface pcm_out_if;
  import pcm_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_used;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  blue_out;

  modport source (output valid, entry_used, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, entry_used, red_out, green_out, blue_out, output ready);
endinterface

### rtl/pcm_div.sv
// Bit-serial restoring divider shared by the index, linear and fraction
// divisions. One quotient bit per cycle. No package dependencies.
module pcm_div #(
  parameter int unsigned QW = 16,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = $clog2(QW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] bits_i,
  input  logic [SW-1:0] steps_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  logic [DW-1:0] rem_q;
  logic [QW-1:0] bits_q;
  logic [QW-1:0] quot_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // Trial subtraction of one step.
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;
  assign trial = {rem_q, bits_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Operands are taken at start; one bit is shifted in per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == SW'(1));
      if (start_i) begin
        rem_q  <= rem_i;
        bits_q <= bits_i;
        den_q  <= den_i;
        quot_q <= '0;
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
        bits_q <= bits_q << 1;
        quot_q <= {quot_q[QW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/pcm_root.sv
// Fifth root of a fraction, one result bit per trial. The trial power is
// built by a limb-serial multiplier, one F by F product per cycle.
module pcm_root #(
  parameter int unsigned FRAC_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FRAC_W-1:0] frac_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] root_o
);

  localparam int unsigned LIMBS = 5;
  localparam int unsigned PW    = LIMBS * FRAC_W;

  typedef enum logic [1:0] {R_IDLE, R_MUL, R_CMP} root_state_e;

  root_state_e       state_q;
  logic [FRAC_W-1:0] frac_q;
  logic [FRAC_W-1:0] root_q;
  logic [FRAC_W-1:0] trial_q;
  logic [FRAC_W-1:0] mask_q;
  logic [PW-1:0]     pow_q;
  logic [FRAC_W-1:0] carry_q;
  logic [2:0]        limb_q;
  logic [1:0]        pass_q;
  logic              done_q;

  // One limb product with the running carry.
  logic [2*FRAC_W-1:0] prod;
  assign prod = (2*FRAC_W)'(pow_q[FRAC_W-1:0]) * (2*FRAC_W)'(trial_q)
              + (2*FRAC_W)'(carry_q);

  // trial^5 <= frac * 2^(4F)
  logic              fits;
  logic [FRAC_W-1:0] root_n;
  logic [FRAC_W-1:0] mask_n;
  assign fits = (pow_q[PW-1:PW-FRAC_W] < frac_q) ||
                ((pow_q[PW-1:PW-FRAC_W] == frac_q) && (pow_q[PW-FRAC_W-1:0] == '0));
  assign root_n = fits ? trial_q : root_q;
  assign mask_n = mask_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      limb_q  <= '0;
      pass_q  <= '0;
    end else begin
      done_q <= (state_q == R_CMP) && mask_q[0];
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            frac_q  <= frac_i;
            root_q  <= '0;
            mask_q  <= {1'b1, {(FRAC_W-1){1'b0}}};
            trial_q <= {1'b1, {(FRAC_W-1){1'b0}}};
            pow_q   <= PW'({1'b1, {(FRAC_W-1){1'b0}}});
            carry_q <= '0;
            limb_q  <= '0;
            pass_q  <= '0;
            state_q <= R_MUL;
          end
        end
        R_MUL: begin
          // Shift the power right by one limb, new limb enters at the top.
          pow_q <= {prod[FRAC_W-1:0], pow_q[PW-1:FRAC_W]};
          if (limb_q == 3'(LIMBS - 1)) begin
            limb_q  <= '0;
            carry_q <= '0;
            if (pass_q == 2'd3) begin
              state_q <= R_CMP;
            end else begin
              pass_q <= pass_q + 1'b1;
            end
          end else begin
            carry_q <= prod[2*FRAC_W-1:FRAC_W];
            limb_q  <= limb_q + 1'b1;
          end
        end
        R_CMP: begin
          root_q <= root_n;
          if (mask_q[0]) begin
            state_q <= R_IDLE;
          end else begin
            mask_q  <= mask_n;
            trial_q <= root_n | mask_n;
            pow_q   <= PW'(root_n | mask_n);
            pass_q  <= '0;
            state_q <= R_MUL;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/pseudo_colour_mapper_unit.sv
// Top level of the pseudo colour mapper: control sequencer, colour table
// memory and bracket search. Uses pcm_pkg, pcm_if, pcm_div and pcm_root.
//
// Usage: an input beat with opcode write stores a control colour in the
// table and gives no result. A map beat turns a sample into a table entry
// and returns its colour as one result beat.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must write them only while the block is idle, as the block
// itself does not enforce it.
// A map beat finds its entry (by the bit-serial divider when the sample is
// inside the range), the bracketing control entries and their colours; a
// control entry is then done. Linear interpolation adds a divider run per
// channel; exponential adds a fraction division and a limb-serial fifth root.
// One item is worked on at a time; input ready is high only while the
// sequencer is idle, so a new beat is taken only once the last is finished.
// The finished result sits in an output register; the next item is taken
// while it waits. A stalled receiver holds the sequencer only when a new
// result is finished before the old one was taken.
// Reset clears the registers to their defaults and marks only the first and
// last entries as control points, blue and red.
module pseudo_colour_mapper_unit #(
  parameter int unsigned TABLE_ENTRIES = pcm_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FRACTION_BITS = pcm_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcm_pkg::SAMPLE_W-1:0]    cfg_data_i,
  pcm_in_if.sink                          in_ch,
  pcm_out_if.source                       out_ch
);
  import pcm_pkg::*;

  localparam int unsigned N     = TABLE_ENTRIES;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned IDX_W = $clog2(N);
  localparam int unsigned NB    = $clog2(N + 1);
  localparam int unsigned QW    = (IDX_W > F) ? ((IDX_W > 8) ? IDX_W : 8) : ((F > 8) ? F : 8);
  localparam int unsigned SW    = $clog2(QW + 1);
  localparam int unsigned NUMW  = SAMPLE_W + NB;
  localparam int unsigned LNW   = CHAN_W + IDX_W + 1;
  localparam int unsigned EW    = CHAN_W + F + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_IDXMUL, ST_IDXDIV, ST_SRCH, ST_RDLO, ST_RDHI,
    ST_CAPHI, ST_LINMUL, ST_LINDIV, ST_FDIV, ST_ROOT, ST_EXPCH, ST_DONE
  } state_e;

  // Highest control entry at or below i.
  function automatic logic [IDX_W-1:0] find_lo(input logic [N-1:0] v,
                                               input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int j = 0; j < N; j++) begin
      if (v[j] && (IDX_W'(j) <= i)) r = IDX_W'(j);
    end
    return r;
  endfunction

  // Lowest control entry at or above i.
  function automatic logic [IDX_W-1:0] find_hi(input logic [N-1:0] v,
                                               input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = LAST;
    for (int j = N - 1; j >= 0; j--) begin
      if (v[j] && (IDX_W'(j) >= i)) r = IDX_W'(j);
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] c,
                                             input logic [1:0] k);
    logic [CHAN_W-1:0] r;
    case (k)
      2'd0:    r = c[23:16];
      2'd1:    r = c[15:8];
      default: r = c[7:0];
    endcase
    return r;
  endfunction

  // Configuration registers.
  logic [SAMPLE_W-1:0] range_low_q;
  logic [SAMPLE_W-1:0] range_high_q;
  logic                mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
      mode_q       <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_LOW:   range_low_q  <= cfg_data_i;
        CFG_RANGE_HIGH:  range_high_q <= cfg_data_i;
        CFG_INTERP_MODE: mode_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e              state_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] diff_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    lo_q;
  logic [IDX_W-1:0]    hi_q;
  logic [IDX_W-1:0]    s_q;
  logic [IDX_W-1:0]    d_q;
  logic [COLOR_W-1:0]  color_lo_q;
  logic [COLOR_W-1:0]  color_hi_q;
  logic [1:0]          ch_q;
  logic [CHAN_W-1:0]   res_q [3];
  logic [F-1:0]        root_q;
  logic [N-1:0]        valid_q;
  logic [COLOR_W-1:0]  end_first_q;
  logic [COLOR_W-1:0]  end_last_q;
  logic                out_valid_q;
  logic [ENTRY_W-1:0]  out_entry_q;
  logic [CHAN_W-1:0]   out_red_q;
  logic [CHAN_W-1:0]   out_green_q;
  logic [CHAN_W-1:0]   out_blue_q;

  // Divider and root request registers.
  logic                div_start_q;
  logic [SAMPLE_W-1:0] div_rem_q;
  logic [QW-1:0]       div_bits_q;
  logic [SW-1:0]       div_steps_q;
  logic [SAMPLE_W-1:0] div_den_q;
  logic                div_done;
  logic [QW-1:0]       div_quot;
  logic                root_start_q;
  logic [F-1:0]        root_frac_q;
  logic                root_done;
  logic [F-1:0]        root_res;

  // Input beat decode.
  logic in_fire;
  logic wr_ok;
  logic [IDX_W-1:0]   wr_addr;
  logic [COLOR_W-1:0] wr_color;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_ok       = in_fire && (in_ch.opcode == OP_WRITE) &&
                       (32'(in_ch.entry_index) < N);
  assign wr_addr     = IDX_W'(in_ch.entry_index);
  assign wr_color    = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  // Colour table memory with registered read.
  logic [COLOR_W-1:0] mem [N];
  logic [COLOR_W-1:0] rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  assign rd_addr = (state_q == ST_RDHI) ? hi_q : lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_ok) mem[wr_addr] <= wr_color;
    rd_data_q <= mem[rd_addr];
  end

  // End entries are held in registers so that they have a reset value.
  logic [COLOR_W-1:0] rd_lo_color;
  logic [COLOR_W-1:0] rd_hi_color;
  assign rd_lo_color = (lo_q == '0) ? end_first_q : (lo_q == LAST) ? end_last_q : rd_data_q;
  assign rd_hi_color = (hi_q == '0) ? end_first_q : (hi_q == LAST) ? end_last_q : rd_data_q;

  // Index numerator and linear numerator.
  logic [NUMW-1:0]   idx_num;
  logic [LNW-1:0]    lin_num;
  logic [CHAN_W-1:0] ch_a;
  logic [CHAN_W-1:0] ch_b;
  assign idx_num = NUMW'(diff_q) * NUMW'(N);
  assign ch_a    = chan(color_lo_q, ch_q);
  assign ch_b    = chan(color_hi_q, ch_q);
  assign lin_num = LNW'(ch_a) * LNW'(s_q - d_q) + LNW'(ch_b) * LNW'(d_q);

  // Exponential channel.
  logic              exp_ge;
  logic [CHAN_W-1:0] exp_dif;
  logic [EW-1:0]     exp_prod;
  logic [EW-1:0]     exp_rnd;
  logic [CHAN_W-1:0] exp_val;
  assign exp_ge   = ch_b >= ch_a;
  assign exp_dif  = exp_ge ? (ch_b - ch_a) : (ch_a - ch_b);
  assign exp_prod = EW'(exp_dif) * EW'(root_q);
  assign exp_rnd  = exp_prod + EW'({F{1'b1}});
  assign exp_val  = exp_ge ? (ch_a + CHAN_W'(exp_prod >> F)) : (ch_a - CHAN_W'(exp_rnd >> F));

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= N'(1) | (N'(1) << (N - 1));
      end_first_q  <= COLOR_FIRST;
      end_last_q   <= COLOR_LAST;
      out_valid_q  <= 1'b0;
      div_start_q  <= 1'b0;
      root_start_q <= 1'b0;
      ch_q         <= '0;
    end else begin
      // Start pulses for the divider and the root unit.
      div_start_q  <= (state_q == ST_IDXMUL) || (state_q == ST_LINMUL) ||
                      ((state_q == ST_CAPHI) && (lo_q != hi_q) && (mode_q == MODE_EXP));
      root_start_q <= (state_q == ST_FDIV) && div_done;

      // Result register valid: set on load, cleared when the beat is taken.
      if ((state_q == ST_DONE) && (!out_valid_q || out_ch.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (wr_ok) begin
            valid_q[wr_addr] <= 1'b1;
            if (wr_addr == '0) end_first_q <= wr_color;
            if (wr_addr == LAST) end_last_q <= wr_color;
          end
          if (in_fire && (in_ch.opcode == OP_MAP)) begin
            sample_q <= in_ch.sample;
            state_q  <= ST_PREP;
          end
        end
        ST_PREP: begin
          diff_q <= sample_q - range_low_q;
          if (sample_q >= range_high_q) begin
            idx_q   <= LAST;
            state_q <= ST_SRCH;
          end else if (sample_q > range_low_q) begin
            state_q <= ST_IDXMUL;
          end else begin
            idx_q   <= '0;
            state_q <= ST_SRCH;
          end
        end
        ST_IDXMUL: begin
          div_rem_q   <= SAMPLE_W'(idx_num >> IDX_W);
          div_bits_q  <= QW'(idx_num[IDX_W-1:0]) << (QW - IDX_W);
          div_steps_q <= SW'(IDX_W);
          div_den_q   <= range_high_q - range_low_q;
          state_q     <= ST_IDXDIV;
        end
        ST_IDXDIV: begin
          if (div_done) begin
            idx_q   <= div_quot[IDX_W-1:0];
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          lo_q    <= find_lo(valid_q, idx_q);
          hi_q    <= find_hi(valid_q, idx_q);
          state_q <= ST_RDLO;
        end
        ST_RDLO: begin
          s_q     <= hi_q - lo_q;
          d_q     <= idx_q - lo_q;
          state_q <= ST_RDHI;
        end
        ST_RDHI: begin
          color_lo_q <= rd_lo_color;
          state_q    <= ST_CAPHI;
        end
        ST_CAPHI: begin
          color_hi_q <= rd_hi_color;
          ch_q       <= '0;
          if (lo_q == hi_q) begin
            res_q[0] <= color_lo_q[23:16];
            res_q[1] <= color_lo_q[15:8];
            res_q[2] <= color_lo_q[7:0];
            state_q  <= ST_DONE;
          end else if (mode_q == MODE_LINEAR) begin
            state_q <= ST_LINMUL;
          end else begin
            div_rem_q   <= SAMPLE_W'(d_q);
            div_bits_q  <= '0;
            div_steps_q <= SW'(F);
            div_den_q   <= SAMPLE_W'(s_q);
            state_q     <= ST_FDIV;
          end
        end
        ST_LINMUL: begin
          div_rem_q   <= SAMPLE_W'(lin_num >> CHAN_W);
          div_bits_q  <= QW'(lin_num[CHAN_W-1:0]) << (QW - CHAN_W);
          div_steps_q <= SW'(CHAN_W);
          div_den_q   <= SAMPLE_W'(s_q);
          state_q     <= ST_LINDIV;
        end
        ST_LINDIV: begin
          if (div_done) begin
            res_q[ch_q] <= div_quot[CHAN_W-1:0];
            if (ch_q == 2'd2) begin
              state_q <= ST_DONE;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_LINMUL;
            end
          end
        end
        ST_FDIV: begin
          if (div_done) begin
            root_frac_q <= div_quot[F-1:0];
            state_q     <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            root_q  <= root_res;
            state_q <= ST_EXPCH;
          end
        end
        ST_EXPCH: begin
          res_q[ch_q] <= exp_val;
          if (ch_q == 2'd2) begin
            state_q <= ST_DONE;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
        ST_DONE: begin
          // Load the result register once it is free.
          if (!out_valid_q || out_ch.ready) begin
            out_entry_q <= ENTRY_W'(idx_q);
            out_red_q   <= res_q[0];
            out_green_q <= res_q[1];
            out_blue_q  <= res_q[2];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  pcm_div #(
    .QW (QW),
    .DW (SAMPLE_W),
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .rem_i   (div_rem_q),
    .bits_i  (div_bits_q),
    .steps_i (div_steps_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  pcm_root #(
    .FRAC_W (F)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start_q),
    .frac_i  (root_frac_q),
    .done_o  (root_done),
    .root_o  (root_res)
  );

  assign out_ch.valid      = out_valid_q;
  assign out_ch.entry_used = out_entry_q;
  assign out_ch.red_out    = out_red_q;
  assign out_ch.green_out  = out_green_q;
  assign out_ch.blue_out   = out_blue_q;

endmodule
